@@ src/fbtp_pkg.sv @@
// ----------------------------------------------------------------------------
// fbtp_pkg: shared types and constants of the float byte truncating packer
// Payload structs of the three channels, the queue entry and the helper
// that turns a precision in bits into a count of kept high bytes.
// ----------------------------------------------------------------------------
package fbtp_pkg;

   localparam int BYTE_BITS        = 8;
   localparam int WORD_BYTES       = 4;
   localparam int PEND_BYTES       = WORD_BYTES - 1;
   localparam int QUEUE_DEPTH_DEF  = 2;
   localparam logic [5:0] KEPT_BITS_RESET = 6'd32;
   localparam logic [5:0] KEPT_BITS_MIN   = 6'd1;
   localparam logic [5:0] KEPT_BITS_MAX   = 6'd32;
   localparam logic [2:0] FULL_COUNT      = 3'd4;

   typedef struct packed {
      logic [31:0] value;
      logic        is_last;
   } req_type;

   typedef struct packed {
      logic [31:0] packed_word;
      logic [2:0]  byte_count;
      logic        final_word;
   } rsp_type;

   typedef struct packed {
      logic [5:0] kept_bits;
   } csr_type;

   // A job holds the one or two words of one accepted float; both travel together.
   typedef struct packed {
      rsp_type res0;
      rsp_type res1;
      logic    two;
   } job_type;

   // ceil(bits / 8) with the precision clamped to 1..32
   function automatic logic [2:0] kept_bytes(input logic [5:0] bits);
      logic [5:0] b;
      logic [5:0] s;
      b = bits;
      if (b < KEPT_BITS_MIN) b = KEPT_BITS_MIN;
      if (b > KEPT_BITS_MAX) b = KEPT_BITS_MAX;
      s = b + 6'd7;
      return s[5:3];
   endfunction

endpackage

@@ src/fbtp_if.sv @@
// ----------------------------------------------------------------------------
// fbtp_if: valid/ready channel
// Carries one payload word per handshake; source drives valid and payload.
// ----------------------------------------------------------------------------
interface fbtp_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ src/float_byte_truncating_packer_top.sv @@
// ----------------------------------------------------------------------------
// float_byte_truncating_packer_top: float byte truncating packer
// Keeps the top ceil(kept_bits/8) bytes of each float and packs them into
// 32-bit words, earliest byte in the low lane.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  takes one float per word with is_last marking the end of a stream.
//   rsp_ch  returns packed words with a byte count and a final flag.
//   csr_ch  writes kept_bits; write only while the block is idle.
// Throughput: one float per cycle while the queue has room. A float gives
//   zero, one or two words; the output register sends one word per cycle while
//   rsp_ch.ready is high, and sends both words of a two-word float in turn.
// Path: a float is realigned and written into the job queue at the accepting
//   edge, then loaded into the output register, from which it leaves when
//   rsp_ch.ready is high.
// Stall: when rsp_ch.ready is low the output register holds its word and the
//   job queue (QUEUE_DEPTH entries) fills; req_ch.ready drops once it is full.
// Reset: kept_bits returns to 32, pending bytes and queue are emptied.
// ----------------------------------------------------------------------------
module float_byte_truncating_packer_top #(
   parameter int QUEUE_DEPTH = fbtp_pkg::QUEUE_DEPTH_DEF
) (
   input logic    clock,
   input logic    reset,
   fbtp_if.sink   req_ch,
   fbtp_if.source rsp_ch,
   fbtp_if.sink   csr_ch
);
   import fbtp_pkg::*;

   logic    push_valid;
   logic    push_ready;
   job_type push_data;
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_data;

   fbtp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   fbtp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   fbtp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

@@ src/fbtp_front.sv @@
// ----------------------------------------------------------------------------
// fbtp_front: input side of the packer
// Holds the precision register and the pending bytes, realigns each float
// into the byte stream and hands the resulting words to the queue.
// ----------------------------------------------------------------------------
module fbtp_front (
   input  logic              clock,
   input  logic              reset,
   fbtp_if.sink              req_ch,
   fbtp_if.sink              csr_ch,
   output logic              push_valid,
   input  logic              push_ready,
   output fbtp_pkg::job_type push_data
);
   import fbtp_pkg::*;

   logic [5:0]  kept_bits_ff, kept_bits_in;
   logic [23:0] pend_ff, pend_in;
   logic [1:0]  cnt_ff, cnt_in;

   logic        accept;
   logic [2:0]  k;
   logic [2:0]  drop_bytes;
   logic [31:0] kept;
   logic [55:0] acc;
   logic [2:0]  total;
   logic [2:0]  rest;
   logic        has_full;
   logic        has_part;
   logic [23:0] rem;
   rsp_type     full_res;
   rsp_type     part_res;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;

   always_comb begin
      k          = kept_bytes(kept_bits_ff);
      drop_bytes = 3'(WORD_BYTES) - k;
      kept       = req_ch.payload.value >> {drop_bytes, 3'b000};
      acc        = {32'b0, pend_ff} | ({24'b0, kept} << {cnt_ff, 3'b000});
      total      = {1'b0, cnt_ff} + k;
      has_full   = (total >= FULL_COUNT);
      rest       = has_full ? (total - FULL_COUNT) : total;
      rem        = has_full ? acc[55:32] : acc[23:0];
      has_part   = req_ch.payload.is_last && (rest != 3'd0);

      full_res.packed_word = acc[31:0];
      full_res.byte_count  = FULL_COUNT;
      full_res.final_word  = req_ch.payload.is_last && (rest == 3'd0);

      part_res.packed_word = {8'b0, rem};
      part_res.byte_count  = rest;
      part_res.final_word  = 1'b1;

      push_data.res0 = has_full ? full_res : part_res;
      push_data.res1 = part_res;
      push_data.two  = has_full && has_part;
      push_valid     = accept && (has_full || has_part);
   end

   always_comb begin
      kept_bits_in = kept_bits_ff;
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      if (csr_ch.valid) begin
         kept_bits_in = csr_ch.payload.kept_bits;
      end
      if (accept) begin
         // clear the stream after the last float
         if (req_ch.payload.is_last) begin
            pend_in = '0;
            cnt_in  = '0;
         end else begin
            pend_in = rem;
            cnt_in  = rest[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_bits_ff <= KEPT_BITS_RESET;
         pend_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         kept_bits_ff <= kept_bits_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.payload.is_last |=> cnt_ff == 2'd0 && pend_ff == 24'd0)
      else $error("pending bytes survive a last word");

endmodule

@@ src/fbtp_queue.sv @@
// ----------------------------------------------------------------------------
// fbtp_queue: short FIFO between front and back
// Holds packed-word jobs so the input and output sides stall on their own.
// ----------------------------------------------------------------------------
module fbtp_queue #(
   parameter int DEPTH = fbtp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  fbtp_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output fbtp_pkg::job_type pop_data
);
   import fbtp_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   job_type       mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push;
   logic          do_pop;

   assign push_ready = (cnt_ff != FULL_CNT);
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("queue count beyond depth");

endmodule

@@ src/fbtp_back.sv @@
// ----------------------------------------------------------------------------
// fbtp_back: output side of the packer
// Pops jobs from the queue and sends their one or two words through the
// output register, first word first.
// ----------------------------------------------------------------------------
module fbtp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  fbtp_pkg::job_type pop_data,
   fbtp_if.source            rsp_ch
);
   import fbtp_pkg::*;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    second_ff, second_in;
   logic    load;

   assign load           = !out_valid_ff || rsp_ch.ready;
   assign pop_ready      = load && (second_ff || !pop_data.two);
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      second_in    = second_ff;
      if (load) begin
         out_valid_in = pop_valid;
         if (pop_valid) begin
            out_in = second_ff ? pop_data.res1 : pop_data.res0;
            // hold the job for its second word
            second_in = !second_ff && pop_data.two;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         second_ff    <= second_in;
      end
      out_ff <= out_in;
   end

   a_second_has_job: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> pop_valid && pop_data.two)
      else $error("second word pending without a two-word job");

   a_partial_is_final: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.byte_count != FULL_COUNT |-> out_ff.final_word)
      else $error("partial word not marked final");

endmodule
